// File: rtl/core/utf8_text_normalizer_assert.svh
// Assertion macros used by the normalizer top level.
`ifndef UTF8_TEXT_NORMALIZER_ASSERT_SVH
`define UTF8_TEXT_NORMALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utn assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UTN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utn assertion failed");

`endif

// File: rtl/core/utn_pkg.sv
// Types and constants shared by the UTF-8 text normalizer modules.
`timescale 1ns / 1ps

package utn_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
   } rsp_type;

   // One command per item that gives any result: an optional space, a one-byte or
   // three-byte character, and an optional end marker.
   typedef struct packed {
      logic       space;
      logic       char_one;
      logic       char_three;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       str_end;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic load;
   } back_status_type;

   // The queue depth must be a power of two so that the pointers wrap by themselves.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int SLOT_SPACE = 0;
   localparam int SLOT_BYTE0 = 1;
   localparam int SLOT_BYTE1 = 2;
   localparam int SLOT_BYTE2 = 3;
   localparam int SLOT_END   = 4;
   localparam int SLOT_COUNT = 5;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] END_BYTE   = 8'h00;

endpackage

// File: rtl/core/utn_front.sv
// Front end: UTF-8 decode, case folding, character classing and space trimming.
`timescale 1ns / 1ps

module utn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  utn_pkg::req_type  req_data,
   output logic              req_full,
   input  logic              q_full,
   output logic              q_push,
   output utn_pkg::cmd_type  q_data
);

   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [20:0] partial_ff, partial_in;
   logic        seen_ff, seen_in;
   logic        space_ff, space_in;
   logic        halted_ff, halted_in;

   logic        accept;
   logic        do_emit;
   logic [20:0] cp;
   logic [20:0] lc;
   logic [20:0] shifted;
   logic        kept;
   logic [7:0]  b;
   utn_pkg::cmd_type cmd;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign b        = req_data.in_byte;

   always_comb begin
      bytes_left_in = bytes_left_ff;
      partial_in    = partial_ff;
      seen_in       = seen_ff;
      space_in      = space_ff;
      halted_in     = halted_ff;
      do_emit       = 1'b0;
      cp            = 21'd0;
      lc            = 21'd0;
      kept          = 1'b0;
      shifted       = {partial_ff[14:0], b[5:0]};
      cmd           = '0;

      if (!halted_ff) begin
         if (bytes_left_ff == 2'd0) begin
            if (!b[7]) begin
               do_emit = 1'b1;
               cp      = {13'd0, b};
            end else if ((b & 8'hE0) == 8'hC0) begin
               bytes_left_in = 2'd1;
               partial_in    = {16'd0, b[4:0]};
            end else if ((b & 8'hF0) == 8'hE0) begin
               bytes_left_in = 2'd2;
               partial_in    = {17'd0, b[3:0]};
            end else if ((b & 8'hF8) == 8'hF0) begin
               bytes_left_in = 2'd3;
               partial_in    = {18'd0, b[2:0]};
            end else begin
               halted_in = 1'b1;
            end
         end else if ((b & 8'hC0) != 8'h80) begin
            halted_in     = 1'b1;
            bytes_left_in = 2'd0;
         end else begin
            bytes_left_in = bytes_left_ff - 2'd1;
            if (bytes_left_ff == 2'd1) begin
               do_emit    = 1'b1;
               cp         = shifted;
               partial_in = 21'd0;
            end else begin
               partial_in = shifted;
            end
         end
      end

      if (do_emit) begin
         if (cp >= 21'h41 && cp <= 21'h5A) begin
            lc = cp + 21'd32;
         end else begin
            lc = cp;
         end
         kept = (lc >= 21'h61 && lc <= 21'h7A) || (lc >= 21'h30 && lc <= 21'h39) ||
                (lc >= 21'h900 && lc <= 21'h97F);
         if (!kept) begin
            if (seen_ff) begin
               space_in = 1'b1;
            end
         end else begin
            cmd.space = space_ff && seen_ff;
            space_in  = 1'b0;
            seen_in   = 1'b1;
            if (lc < 21'h80) begin
               cmd.char_one = 1'b1;
               cmd.byte0    = lc[7:0];
            end else begin
               cmd.char_three = 1'b1;
               cmd.byte0      = {4'hE, lc[15:12]};
               cmd.byte1      = {2'b10, lc[11:6]};
               cmd.byte2      = {2'b10, lc[5:0]};
            end
         end
      end

      if (req_data.string_end) begin
         cmd.str_end   = 1'b1;
         bytes_left_in = 2'd0;
         partial_in    = 21'd0;
         seen_in       = 1'b0;
         space_in      = 1'b0;
         halted_in     = 1'b0;
      end
   end

   assign q_push = accept && (cmd.space || cmd.char_one || cmd.char_three || cmd.str_end);
   assign q_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 2'd0;
         partial_ff    <= 21'd0;
         seen_ff       <= 1'b0;
         space_ff      <= 1'b0;
         halted_ff     <= 1'b0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         partial_ff    <= partial_in;
         seen_ff       <= seen_in;
         space_ff      <= space_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

// File: rtl/core/utn_cmd_queue.sv
// Short command queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module utn_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  utn_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output utn_pkg::cmd_type  head
);

   utn_pkg::cmd_type entries_ff [utn_pkg::QUEUE_DEPTH];

   logic [utn_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [utn_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [utn_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full    = (count_ff == utn_pkg::QUEUE_CNT_W'(utn_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + utn_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + utn_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + utn_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - utn_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/utn_back.sv
// Back end: expands commands into bytes in an output register, one per cycle unless held.
`timescale 1ns / 1ps

module utn_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  utn_pkg::cmd_type         q_head,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output utn_pkg::rsp_type         rsp_data,
   output utn_pkg::back_status_type status
);

   logic [utn_pkg::SLOT_COUNT-1:0] mask_ff, mask_in;
   logic [utn_pkg::SLOT_COUNT-1:0] mask_after;
   logic [utn_pkg::SLOT_COUNT-1:0] pick;
   logic [utn_pkg::SLOT_COUNT-1:0] head_mask;
   logic [7:0]                     byte0_ff, byte1_ff, byte2_ff;
   logic                           out_valid_ff, out_valid_in;
   utn_pkg::rsp_type               out_ff, out_in;
   logic                           advance;
   logic                           emit;
   logic                           load;

   always_comb begin
      head_mask                      = '0;
      head_mask[utn_pkg::SLOT_SPACE] = q_head.space;
      head_mask[utn_pkg::SLOT_BYTE0] = q_head.char_one || q_head.char_three;
      head_mask[utn_pkg::SLOT_BYTE1] = q_head.char_three;
      head_mask[utn_pkg::SLOT_BYTE2] = q_head.char_three;
      head_mask[utn_pkg::SLOT_END]   = q_head.str_end;
   end

   always_comb begin
      pick   = '0;
      out_in = out_ff;
      if (mask_ff[utn_pkg::SLOT_SPACE]) begin
         pick[utn_pkg::SLOT_SPACE] = 1'b1;
         out_in = '{out_byte: utn_pkg::SPACE_CHAR, end_marker: 1'b0};
      end else if (mask_ff[utn_pkg::SLOT_BYTE0]) begin
         pick[utn_pkg::SLOT_BYTE0] = 1'b1;
         out_in = '{out_byte: byte0_ff, end_marker: 1'b0};
      end else if (mask_ff[utn_pkg::SLOT_BYTE1]) begin
         pick[utn_pkg::SLOT_BYTE1] = 1'b1;
         out_in = '{out_byte: byte1_ff, end_marker: 1'b0};
      end else if (mask_ff[utn_pkg::SLOT_BYTE2]) begin
         pick[utn_pkg::SLOT_BYTE2] = 1'b1;
         out_in = '{out_byte: byte2_ff, end_marker: 1'b0};
      end else if (mask_ff[utn_pkg::SLOT_END]) begin
         pick[utn_pkg::SLOT_END] = 1'b1;
         out_in = '{out_byte: utn_pkg::END_BYTE, end_marker: 1'b1};
      end
   end

   assign advance    = !out_valid_ff || rsp_pop;
   assign emit       = advance && (mask_ff != '0);
   assign mask_after = emit ? (mask_ff & ~pick) : mask_ff;
   assign load       = (mask_after == '0) && !q_empty;
   assign q_pop      = load;
   assign mask_in    = load ? head_mask : mask_after;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte0_ff <= q_head.byte0;
         byte1_ff <= q_head.byte1;
         byte2_ff <= q_head.byte2;
      end
      if (emit) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_data    = out_ff;
   assign status.busy = (mask_ff != '0);
   assign status.load = load;

endmodule

// File: rtl/core/utf8_text_normalizer.sv
// Top level of the streaming UTF-8 text normalizer.
//
//   Channel   Handshake             Payload                          Direction
//   req       req_push / req_full   req_data (in_byte, string_end)   in
//   rsp       rsp_empty / rsp_pop   rsp_data (out_byte, end_marker)  out
//
// The front end takes one input item per cycle while the command queue is not full, and decodes it in the same cycle.
// The back end sends one result byte per cycle from its output register while that register is empty or popped;
// an item gives k result bytes (k is 0 to 5), sent one after another.
// A four-entry command queue lets the front keep taking items while the back drains.
// Reset is synchronous and clears all string state, the queue and the output valid flag.
// req_full rises only when the command queue is full.
`timescale 1ns / 1ps
`include "utf8_text_normalizer_assert.svh"

module utf8_text_normalizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  utn_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output utn_pkg::rsp_type rsp_data
);

   logic                     q_push;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_empty;
   utn_pkg::cmd_type         q_wdata;
   utn_pkg::cmd_type         q_head;
   utn_pkg::back_status_type back_status;
   logic                     req_accept;
   logic                     rsp_end_seen;

   utn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   utn_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   utn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .status    (back_status)
   );

   assign req_accept   = req_push && !req_full;
   assign rsp_end_seen = !rsp_empty && rsp_data.end_marker;

   `UTN_ASSERT_IMPLY(a_end_enqueued, clock, reset, req_accept && req_data.string_end, q_push)
   `UTN_ASSERT_NEXT(a_back_picks_up, clock, reset, !q_empty && !back_status.busy, back_status.busy)
   `UTN_ASSERT_IMPLY(a_end_byte_zero, clock, reset, rsp_end_seen, rsp_data.out_byte == 8'h00)
   `UTN_ASSERT_IMPLY(a_load_has_entry, clock, reset, back_status.load, !q_empty)

endmodule
